FILE: sv/esst_pkg.sv
// ============================================================================
// esst_pkg
// Shared types, constants and key functions of the directory entry sorter.
// ============================================================================
package esst_pkg;

    // Table depth and derived widths
    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;

    // Seconds within a month: up to 31*86400 + 31*3600 + 63*60 + 63 < 2^22
    localparam int DSEC_W = 22;
    localparam logic [DSEC_W-1:0] SECS_PER_DAY  = DSEC_W'(86400);
    localparam logic [DSEC_W-1:0] SECS_PER_HOUR = DSEC_W'(3600);
    localparam logic [DSEC_W-1:0] SECS_PER_MIN  = DSEC_W'(60);

    // Stream data width, whole bytes
    localparam int TDATA_W = 120;

    // Commands (tuser on the input side)
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Sort modes
    localparam logic MODE_SIZE = 1'b0;
    localparam logic MODE_TIME = 1'b1;

    // One directory entry, tag in the lowest bits (same layout as tdata)
    typedef struct packed {
        logic        folder;
        logic [62:0] size;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [9:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Memory row: entry plus its precomputed seconds-in-month key
    typedef struct packed {
        logic [DSEC_W-1:0] dsec;
        entry_t            ent;
    } row_t;

    // Memory port command from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        row_t              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_cmd_t;

    // Fetch result request, taken into the output stage in the cycle after it is issued
    typedef struct packed {
        logic valid;
        logic none;
        logic last;
    } fetch_req_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_RD_I,
        ST_GET_I,
        ST_SCAN,
        ST_PUT_I
    } state_t;

    // day*86400 + hour*3600 + minute*60 + second
    function automatic logic [DSEC_W-1:0] day_seconds(input entry_t e);
        day_seconds = DSEC_W'(e.day) * SECS_PER_DAY
                    + DSEC_W'(e.hour) * SECS_PER_HOUR
                    + DSEC_W'(e.minute) * SECS_PER_MIN
                    + DSEC_W'(e.second);
    endfunction

    // True when row b must move ahead of row a (strictly greater key)
    function automatic logic key_greater(input row_t b, input row_t a, input logic mode);
        if (mode == MODE_SIZE)
        begin
            key_greater = (b.ent.size > a.ent.size);
        end
        else
        begin
            key_greater = ({b.ent.year, b.ent.month, b.dsec} >
                           {a.ent.year, a.ent.month, a.dsec});
        end
    endfunction

endpackage

FILE: sv/esst_ram.sv
// ============================================================================
// esst_ram
// Entry table: one write and one read a cycle, registered read.
// ============================================================================
module esst_ram (
    input  logic              clk,
    input  esst_pkg::ram_cmd_t cmd,
    output esst_pkg::row_t    rd_data
);
    import esst_pkg::*;

    row_t mem [MAX_ENTRIES];
    row_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rd_data_reg <= mem[cmd.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/esst_ctrl.sv
// ============================================================================
// esst_ctrl
// Load, exchange-sort and fetch sequencer around the entry table.
// ============================================================================
module esst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_cmd,
    input  esst_pkg::entry_t     s_ent,
    input  logic                 s_last,
    // configuration
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    // output stage
    input  logic                 out_free,
    output esst_pkg::fetch_req_t req,
    // table
    input  esst_pkg::row_t       rd_data,
    output esst_pkg::ram_cmd_t   ram_cmd
);
    import esst_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rptr_reg, rptr_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic              sort_mode_reg;
    logic              mode_reg, mode_next;
    fetch_req_t        req_reg, req_next;
    row_t              hold_reg, hold_next;
    logic [CNT_W-1:0]  cnt_base;
    logic              accept;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            rptr_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            mode_reg  <= MODE_SIZE;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rptr_reg  <= rptr_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            mode_reg  <= mode_next;
            req_reg   <= req_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg <= MODE_SIZE;
        end
        else if (cfg_valid)
        begin
            sort_mode_reg <= cfg_data;
        end
    end

    // Entry held at position i during a scan pass
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign s_tready = ((state_reg == ST_LOAD) || (state_reg == ST_FETCH)) &&
                      !req_reg.valid && out_free;
    assign accept   = s_tvalid && s_tready;
    // a load after the sort starts a new table
    assign cnt_base = (state_reg == ST_FETCH) ? '0 : count_reg;

    // Next state and memory commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rptr_next  = rptr_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mode_next  = mode_reg;
        hold_next  = hold_reg;
        req_next   = '0;
        ram_cmd    = '0;

        case (state_reg)
            ST_LOAD, ST_FETCH:
            begin
                if (accept && (s_cmd == CMD_LOAD))
                begin
                    count_next = cnt_base;
                    rptr_next  = '0;
                    state_next = ST_LOAD;
                    if (cnt_base < CNT_W'(MAX_ENTRIES))
                    begin
                        ram_cmd.we         = 1'b1;
                        ram_cmd.waddr      = cnt_base[ADDR_W-1:0];
                        ram_cmd.wdata.ent  = s_ent;
                        ram_cmd.wdata.dsec = day_seconds(s_ent);
                        count_next         = cnt_base + CNT_W'(1);
                    end
                    if (s_last)
                    begin
                        mode_next  = sort_mode_reg;
                        i_next     = '0;
                        state_next = (count_next >= CNT_W'(2)) ? ST_RD_I : ST_FETCH;
                    end
                end
                else if (accept)
                begin
                    req_next.valid = 1'b1;
                    if ((state_reg == ST_FETCH) && (rptr_reg < count_reg))
                    begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = rptr_reg[ADDR_W-1:0];
                        req_next.last = ((rptr_reg + CNT_W'(1)) == count_reg);
                        rptr_next     = rptr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        req_next.none = 1'b1;
                    end
                end
            end

            // read the entry at position i
            ST_RD_I:
            begin
                ram_cmd.re    = 1'b1;
                ram_cmd.raddr = i_reg;
                state_next    = ST_GET_I;
            end

            // hold entry i, start reading j = i + 1
            ST_GET_I:
            begin
                hold_next     = rd_data;
                ram_cmd.re    = 1'b1;
                ram_cmd.raddr = i_reg + ADDR_W'(1);
                j_next        = i_reg + ADDR_W'(1);
                state_next    = ST_SCAN;
            end

            // compare entry j with the held one, swap when strictly greater
            ST_SCAN:
            begin
                if (key_greater(rd_data, hold_reg, mode_reg))
                begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = j_reg;
                    ram_cmd.wdata = hold_reg;
                    hold_next     = rd_data;
                end
                if (({1'b0, j_reg} + CNT_W'(1)) < count_reg)
                begin
                    ram_cmd.re    = 1'b1;
                    ram_cmd.raddr = j_reg + ADDR_W'(1);
                    j_next        = j_reg + ADDR_W'(1);
                end
                else
                begin
                    state_next = ST_PUT_I;
                end
            end

            // write the winner back to position i
            ST_PUT_I:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = i_reg;
                ram_cmd.wdata = hold_reg;
                if (({1'b0, i_reg} + CNT_W'(2)) < count_reg)
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_RD_I;
                end
                else
                begin
                    rptr_next  = '0;
                    state_next = ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign req = req_reg;

endmodule

FILE: sv/esst_out.sv
// ============================================================================
// esst_out
// Output register for fetch results, holds a word until it is taken.
// ============================================================================
module esst_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esst_pkg::fetch_req_t req,
    input  esst_pkg::row_t       rd_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output esst_pkg::entry_t     m_ent,
    output logic                 m_last,
    output logic                 m_none,
    output logic                 out_free
);
    import esst_pkg::*;

    logic   valid_reg;
    entry_t ent_reg;
    logic   last_reg;
    logic   none_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, zeros when no entry is left
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            ent_reg  <= req.none ? '0 : rd_data.ent;
            last_reg <= req.last && !req.none;
            none_reg <= req.none;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_ent    = ent_reg;
    assign m_last   = last_reg;
    assign m_none   = none_reg;
    assign out_free = !valid_reg || m_tready;

endmodule

FILE: sv/entry_sort_by_size_or_time.sv
// ============================================================================
// entry_sort_by_size_or_time
// Directory entry sorter: loads a table, exchange-sorts it by size or by
// timestamp (descending), then returns the sorted entries on fetch.
// ============================================================================
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser: command; tdata: entry fields; tlast: last load
//  m_*      | out       | tdata: sorted entry; tlast: final one; tuser: none left
//  cfg_*    | in        | sort_mode (0 size, 1 timestamp)
//
//  Loads are accepted back to back; a fetch word passes the request register and then
//  the output register, and no new input word is taken until it lands. After the last
//  load the sort walks the table, at most one read and one write a cycle, s_tready low.
//  Reset clears the count, pointers and state; table contents are not cleared.
//  A word held on m_* while m_tready is low blocks new input words.
//
module entry_sort_by_size_or_time (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: entry_tag, stamp_year, stamp_month, stamp_day, stamp_hour,
    //        stamp_minute, stamp_second, byte_size, is_folder, zero pad
    input  logic [esst_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,   // command
    input  logic                          s_tlast,   // last_entry
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: out_tag, out_year, out_month, out_day, out_hour, out_minute,
    //        out_second, out_size, out_folder, zero pad
    output logic [esst_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,   // none_left
    output logic                          m_tlast,   // final_one
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data   // sort_mode
);
    import esst_pkg::*;

    ram_cmd_t   ram_cmd;
    row_t       rd_data;
    fetch_req_t req;
    entry_t     s_ent;
    entry_t     m_ent;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign s_ent     = entry_t'(s_tdata[ENTRY_W-1:0]);
    assign m_tdata   = {(TDATA_W - ENTRY_W)'(0), m_ent};

    // Sequencer
    esst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_ent    (s_ent),
        .s_last   (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .out_free (out_free),
        .req      (req),
        .rd_data  (rd_data),
        .ram_cmd  (ram_cmd)
    );

    // Entry table
    esst_ram u_ram (
        .clk    (clk),
        .cmd    (ram_cmd),
        .rd_data(rd_data)
    );

    // Output register
    esst_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_ent   (m_ent),
        .m_last  (m_tlast),
        .m_none  (m_tuser),
        .out_free(out_free)
    );

endmodule

FILE: sv/esst_check.sv
// ============================================================================
// esst_check
// Port-level checks for the directory entry sorter, bound to the top level.
// ============================================================================
module esst_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [esst_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);
    import esst_pkg::*;

    // An empty fetch result carries no entry and is never the final one
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata == '0) && !m_tlast))
        else $error("none_left word carries data");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("output word changed while stalled");

    // Every fetch yields a word once it has passed the request and output registers
    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_FETCH)) |=> ##1 m_tvalid)
        else $error("fetch gave no result");

    // No new word is taken while a fetch result is in flight
    a_fetch_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_FETCH)) |=> !s_tready)
        else $error("input taken during pending fetch");

endmodule

bind entry_sort_by_size_or_time esst_check u_check (.*);
